>>> hdl/b2dc_pkg.sv
// Shared constants, state encoding and interface structs for the two-dimensional checksum core.
package b2dc_pkg;

   localparam int DEF_MAX_LINE_BYTES = 64;
   localparam int MIN_LINE_LEN = 3;
   localparam logic [6:0] LINE_LENGTH_RESET = 7'd61;

   localparam logic OP_READ = 1'b1;
   localparam logic LINE_DIAG = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD,
      ST_MOD_N,
      ST_MOD_X,
      ST_BYTE_RD,
      ST_BYTE_WR,
      ST_CL_RD,
      ST_CL_WR,
      ST_CL_END,
      ST_RESULT
   } ctl_state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear;
   } mem_ctl_type;

   typedef struct packed {
      logic [7:0] check_byte;
      logic       group_closed;
   } result_type;

endpackage

>>> hdl/b2dc_sum_mem.sv
// Sum memory: synchronous RAM with registered read data and per-entry valid bits; invalid entries read as zero.
module b2dc_sum_mem
   import b2dc_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_LINE_BYTES + 1,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  mem_ctl_type   ctl,
   input  logic [AW-1:0] rd_addr,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   output logic [7:0]    rd_data
);

   logic [7:0]       mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;
   logic [7:0]       rd_data_ff;
   logic             rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = '0;
      end else if (ctl.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (ctl.rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : 8'd0;

endmodule

>>> hdl/b2dc_ctrl.sv
// Sequencer: sum reads, slot reduction, read-modify-write of both sum memories and group closing.
module b2dc_ctrl
   import b2dc_pkg::*;
#(
   parameter int MAX_LINE_BYTES = DEF_MAX_LINE_BYTES,
   parameter int AW             = $clog2(MAX_LINE_BYTES + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [AW-1:0] len,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_opcode,
   input  logic [7:0]    req_data_byte,
   input  logic          req_final_line,
   input  logic          req_read_line,
   input  logic [5:0]    req_read_index,
   input  logic          res_take,
   output logic          res_valid,
   output result_type    res,
   output mem_ctl_type   vert_ctl,
   output logic [AW-1:0] vert_rd_addr,
   output logic [AW-1:0] vert_wr_addr,
   output logic [7:0]    vert_wr_data,
   input  logic [7:0]    vert_rd_data,
   output mem_ctl_type   diag_ctl,
   output logic [AW-1:0] diag_rd_addr,
   output logic [AW-1:0] diag_wr_addr,
   output logic [7:0]    diag_wr_data,
   input  logic [7:0]    diag_rd_data
);

   localparam int XW = AW + 2;

   ctl_state_type state_ff, state_in;

   logic [AW-1:0] pos_ff, pos_in;
   logic [AW-1:0] line_ff, line_in;
   logic          clear_pend_ff, clear_pend_in;

   logic          op_ff, op_in;
   logic [7:0]    byte_ff, byte_in;
   logic          fin_ff, fin_in;
   logic          hit_ff, hit_in;
   logic          rline_ff, rline_in;
   logic [AW-1:0] raddr_ff, raddr_in;
   logic [AW-1:0] nacc_ff, nacc_in;
   logic [XW-1:0] xacc_ff, xacc_in;
   logic [AW-1:0] slot_ff, slot_in;
   logic [AW-1:0] m_ff, m_in;
   logic [AW-1:0] cl_addr_ff, cl_addr_in;
   logic [7:0]    cl_sub_ff, cl_sub_in;
   logic          closed_ff, closed_in;

   logic          accept;
   logic          last_byte;
   logic          do_close;
   logic          n_ge;
   logic          x_ge;
   logic          m_more;
   logic          rd_hit;
   logic [XW-1:0] x_init;
   logic [AW-1:0] miss_addr;

   assign accept    = req_valid && req_ready;
   assign last_byte = ((AW+1)'(pos_ff) + (AW+1)'(1)) >= (AW+1)'(len);
   assign do_close  = fin_ff || (((AW+1)'(line_ff) + (AW+1)'(1)) >= (AW+1)'(len));
   assign n_ge      = nacc_ff >= len;
   assign x_ge      = xacc_ff >= XW'(len);
   assign m_more    = m_ff < len;
   assign x_init    = XW'(pos_ff) + (XW'(len) << 1) + XW'(1) - XW'(nacc_ff);
   assign miss_addr = AW'((AW+1)'(len) + (AW+1)'(2) - (AW+1)'(m_ff));
   assign rd_hit    = (32'(req_read_index) < 32'(len))
                   && (32'(req_read_index) <= 32'(MAX_LINE_BYTES));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_opcode == OP_READ) ? ST_RD : ST_MOD_N;
            end
         end
         ST_RD:      state_in = ST_RESULT;
         ST_MOD_N:   state_in = n_ge ? ST_MOD_N : ST_MOD_X;
         ST_MOD_X:   state_in = x_ge ? ST_MOD_X : ST_BYTE_RD;
         ST_BYTE_RD: state_in = ST_BYTE_WR;
         ST_BYTE_WR: state_in = (last_byte && do_close) ? ST_CL_RD : ST_RESULT;
         ST_CL_RD:   state_in = ST_CL_WR;
         ST_CL_WR:   state_in = m_more ? ST_CL_RD : ST_CL_END;
         ST_CL_END:  state_in = ST_RESULT;
         ST_RESULT:  state_in = res_take ? ST_IDLE : ST_RESULT;
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready    = 1'b0;
      res_valid    = 1'b0;
      vert_ctl     = '0;
      diag_ctl     = '0;
      vert_rd_addr = '0;
      vert_wr_addr = '0;
      vert_wr_data = '0;
      diag_rd_addr = '0;
      diag_wr_addr = '0;
      diag_wr_data = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_opcode != OP_READ && clear_pend_ff) begin
               vert_ctl.clear = 1'b1;
               diag_ctl.clear = 1'b1;
            end
         end
         ST_RD: begin
            vert_ctl.rd_en = 1'b1;
            diag_ctl.rd_en = 1'b1;
            vert_rd_addr   = raddr_ff;
            diag_rd_addr   = raddr_ff;
         end
         ST_BYTE_RD: begin
            vert_ctl.rd_en = 1'b1;
            diag_ctl.rd_en = 1'b1;
            vert_rd_addr   = pos_ff;
            diag_rd_addr   = slot_ff;
         end
         ST_BYTE_WR: begin
            vert_ctl.wr_en = (pos_ff != '0);
            vert_wr_addr   = pos_ff;
            vert_wr_data   = vert_rd_data - byte_ff;
            diag_ctl.wr_en = 1'b1;
            diag_wr_addr   = slot_ff;
            diag_wr_data   = diag_rd_data - byte_ff;
         end
         ST_CL_RD: begin
            diag_ctl.rd_en = 1'b1;
            diag_rd_addr   = cl_addr_ff;
         end
         ST_CL_WR: begin
            diag_ctl.wr_en = 1'b1;
            diag_wr_addr   = cl_addr_ff;
            diag_wr_data   = diag_rd_data - cl_sub_ff;
         end
         ST_CL_END: begin
            vert_ctl.wr_en = 1'b1;
            vert_wr_addr   = '0;
            vert_wr_data   = 8'(len);
            diag_ctl.wr_en = 1'b1;
            diag_wr_addr   = '0;
            diag_wr_data   = 8'(len) + 8'd2;
         end
         ST_RESULT: res_valid = 1'b1;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      res.check_byte   = 8'd0;
      res.group_closed = closed_ff;
      if (op_ff == OP_READ && hit_ff) begin
         res.check_byte = (rline_ff == LINE_DIAG) ? diag_rd_data : vert_rd_data;
      end
   end

   // datapath next values
   always_comb begin
      pos_in        = pos_ff;
      line_in       = line_ff;
      clear_pend_in = clear_pend_ff;
      op_in         = op_ff;
      byte_in       = byte_ff;
      fin_in        = fin_ff;
      hit_in        = hit_ff;
      rline_in      = rline_ff;
      raddr_in      = raddr_ff;
      nacc_in       = nacc_ff;
      xacc_in       = xacc_ff;
      slot_in       = slot_ff;
      m_in          = m_ff;
      cl_addr_in    = cl_addr_ff;
      cl_sub_in     = cl_sub_ff;
      closed_in     = closed_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in     = req_opcode;
               byte_in   = req_data_byte;
               fin_in    = req_final_line;
               hit_in    = rd_hit;
               rline_in  = req_read_line;
               raddr_in  = AW'(req_read_index);
               nacc_in   = line_ff;
               closed_in = 1'b0;
               if (req_opcode != OP_READ) begin
                  clear_pend_in = 1'b0;
               end
            end
         end
         ST_MOD_N: begin
            if (n_ge) begin
               nacc_in = nacc_ff - len;
            end else begin
               xacc_in = x_init;
            end
         end
         ST_MOD_X: begin
            if (x_ge) begin
               xacc_in = xacc_ff - XW'(len);
            end else begin
               slot_in = AW'(xacc_ff) + AW'(1);
            end
         end
         ST_BYTE_WR: begin
            if (last_byte) begin
               pos_in = '0;
               if (do_close) begin
                  line_in       = AW'(1);
                  clear_pend_in = 1'b1;
                  closed_in     = 1'b1;
                  cl_addr_in    = AW'(2);
                  cl_sub_in     = 8'(len);
                  m_in          = line_ff + AW'(1);
               end else begin
                  line_in = line_ff + AW'(1);
               end
            end else begin
               pos_in = pos_ff + AW'(1);
            end
         end
         ST_CL_WR: begin
            if (m_more) begin
               cl_addr_in = miss_addr;
               cl_sub_in  = 8'(m_ff);
               m_in       = m_ff + AW'(1);
            end
         end
         default: begin
            closed_in = closed_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pos_ff        <= '0;
         line_ff       <= AW'(1);
         clear_pend_ff <= 1'b1;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         line_ff       <= line_in;
         clear_pend_ff <= clear_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      byte_ff    <= byte_in;
      fin_ff     <= fin_in;
      hit_ff     <= hit_in;
      rline_ff   <= rline_in;
      raddr_ff   <= raddr_in;
      nacc_ff    <= nacc_in;
      xacc_ff    <= xacc_in;
      slot_ff    <= slot_in;
      m_ff       <= m_in;
      cl_addr_ff <= cl_addr_in;
      cl_sub_ff  <= cl_sub_in;
      closed_ff  <= closed_in;
   end

endmodule

>>> hdl/block_two_dimensional_checksum_core.sv
// Top level of the two-dimensional checksum core: config register, sequencer, sum memories, result register.
//
//   channel  ports                                              direction
//   csr      csr_valid/csr_ready, csr_line_length               in
//   req      req_valid/req_ready, opcode, data_byte, final_line,
//            read_line, read_index                              in
//   rsp      rsp_valid/rsp_ready, check_byte, group_closed      out
//
// A read transfer passes through ST_RD and ST_RESULT. A data byte first reduces the line number and
// then the diagonal slot modulo L by repeated subtraction of L, then read-modify-writes the sum memories;
// a closing byte adds one read-modify-write on the diagonal memory for entry 2 and one per missing line.
// Reset clears valid bits of both memories at once; no clearing pass.
// The result register lets the sequencer finish while rsp is stalled; it waits only to load.
module block_two_dimensional_checksum_core
   import b2dc_pkg::*;
#(
   parameter int MAX_LINE_BYTES = DEF_MAX_LINE_BYTES
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [6:0] csr_line_length,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_opcode,
   input  logic [7:0] req_data_byte,
   input  logic       req_final_line,
   input  logic       req_read_line,
   input  logic [5:0] req_read_index,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_check_byte,
   output logic       rsp_group_closed
);

   localparam int AW = $clog2(MAX_LINE_BYTES + 1);

   logic [6:0]    line_length_ff, line_length_in;
   logic [AW-1:0] len;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_check_byte_ff;
   logic          rsp_group_closed_ff;

   logic          res_valid;
   logic          res_take;
   result_type    res;

   mem_ctl_type   vert_ctl, diag_ctl;
   logic [AW-1:0] vert_rd_addr, vert_wr_addr, diag_rd_addr, diag_wr_addr;
   logic [7:0]    vert_wr_data, vert_rd_data, diag_wr_data, diag_rd_data;

   assign csr_ready      = 1'b1;
   assign line_length_in = (csr_valid && csr_ready) ? csr_line_length : line_length_ff;

   always_comb begin
      if (line_length_ff < 7'(MIN_LINE_LEN)) begin
         len = AW'(MIN_LINE_LEN);
      end else if (32'(line_length_ff) > 32'(MAX_LINE_BYTES)) begin
         len = AW'(MAX_LINE_BYTES);
      end else begin
         len = AW'(line_length_ff);
      end
   end

   assign res_take     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = (res_valid && res_take) ? 1'b1 :
                         (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= LINE_LENGTH_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         line_length_ff <= line_length_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_take) begin
         rsp_check_byte_ff   <= res.check_byte;
         rsp_group_closed_ff <= res.group_closed;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_check_byte   = rsp_check_byte_ff;
   assign rsp_group_closed = rsp_group_closed_ff;

   b2dc_ctrl #(
      .MAX_LINE_BYTES (MAX_LINE_BYTES),
      .AW             (AW)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .len            (len),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_data_byte  (req_data_byte),
      .req_final_line (req_final_line),
      .req_read_line  (req_read_line),
      .req_read_index (req_read_index),
      .res_take       (res_take),
      .res_valid      (res_valid),
      .res            (res),
      .vert_ctl       (vert_ctl),
      .vert_rd_addr   (vert_rd_addr),
      .vert_wr_addr   (vert_wr_addr),
      .vert_wr_data   (vert_wr_data),
      .vert_rd_data   (vert_rd_data),
      .diag_ctl       (diag_ctl),
      .diag_rd_addr   (diag_rd_addr),
      .diag_wr_addr   (diag_wr_addr),
      .diag_wr_data   (diag_wr_data),
      .diag_rd_data   (diag_rd_data)
   );

   b2dc_sum_mem #(
      .DEPTH (MAX_LINE_BYTES + 1),
      .AW    (AW)
   ) u_vert_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (vert_ctl),
      .rd_addr (vert_rd_addr),
      .wr_addr (vert_wr_addr),
      .wr_data (vert_wr_data),
      .rd_data (vert_rd_data)
   );

   b2dc_sum_mem #(
      .DEPTH (MAX_LINE_BYTES + 1),
      .AW    (AW)
   ) u_diag_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (diag_ctl),
      .rd_addr (diag_rd_addr),
      .wr_addr (diag_wr_addr),
      .wr_data (diag_wr_data),
      .rd_data (diag_rd_data)
   );

   // one item in flight: ready drops after every request transfer
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while an item is still in flight");

   a_no_result_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !res_valid)
      else $error("sequencer offers a result while idle");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_take) |=> rsp_valid_ff)
      else $error("result handed over but not presented");

   a_close_no_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_group_closed_ff) |-> (rsp_check_byte_ff == 8'd0))
      else $error("group close reported together with a check byte");

endmodule

>>> verif/tb_block_two_dimensional_checksum_core.sv
// Self-checking testbench for the two-dimensional checksum core: directed then random transfers.
module tb_block_two_dimensional_checksum_core;
   timeunit 1ns;
   timeprecision 1ps;
   import b2dc_pkg::*;

   localparam logic OP_BYTE = ~OP_READ;
   localparam logic LINE_VERT = ~LINE_DIAG;
   localparam int MAX_BYTES = DEF_MAX_LINE_BYTES;
   localparam int STALL_LIMIT = 4000;
   localparam int PHASE_ITEMS = 135;
   localparam int DRAIN_CYCLES = 150;
   localparam int NUM_PHASES = 12;
   localparam logic [6:0] PHASE_LENGTHS [0:NUM_PHASES-1] = '{
      7'd4, 7'd127, 7'd5, 7'd8, 7'd2, 7'd64, 7'd11, 7'd3, 7'd65, 7'd6, 7'd24, 7'd7
   };

   typedef struct packed {
      logic       opcode;
      logic [7:0] data_byte;
      logic       final_line;
      logic       read_line;
      logic [5:0] read_index;
   } checksum_req_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [6:0] csr_line_length = '0;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_opcode = 1'b0;
   logic [7:0] req_data_byte = '0;
   logic       req_final_line = 1'b0;
   logic       req_read_line = 1'b0;
   logic [5:0] req_read_index = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_check_byte;
   logic       rsp_group_closed;

   checksum_req_type pending_reqs[$];
   result_type       expected_results[$];
   int               mismatches = 0;
   int               stall_cycles = 0;
   int               send_idle_pct = 13;
   int               recv_idle_pct = 76;

   // predictor state
   logic [7:0]  vert_sum [0:MAX_BYTES];
   logic [7:0]  diag_sum [0:MAX_BYTES];
   int unsigned line_no;
   int unsigned byte_pos;
   bit          clear_due;
   logic [6:0]  line_length_q;

   // stimulus-side view of line position
   int unsigned gen_len = 61;
   int unsigned gen_pos = 0;
   int unsigned gen_line = 1;
   int          phase_count = 0;

   block_two_dimensional_checksum_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_line_length  (csr_line_length),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_data_byte    (req_data_byte),
      .req_final_line   (req_final_line),
      .req_read_line    (req_read_line),
      .req_read_index   (req_read_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_check_byte   (rsp_check_byte),
      .rsp_group_closed (rsp_group_closed)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned saturated_length(input logic [6:0] v);
      if (v < MIN_LINE_LEN) return MIN_LINE_LEN;
      if (v > MAX_BYTES) return MAX_BYTES;
      return 32'(v);
   endfunction

   function automatic int unsigned diag_entry(input int unsigned n, input int unsigned p,
                                              input int unsigned l);
      return ((l + 1 + p + l - (n % l)) % l) + 1;
   endfunction

   function automatic void take_off_diag(input int unsigned idx, input int unsigned v);
      if (idx <= MAX_BYTES) diag_sum[idx] = diag_sum[idx] - v[7:0];
   endfunction

   function automatic void clear_sums();
      int i;
      for (i = 0; i <= MAX_BYTES; i++) begin
         vert_sum[i] = '0;
         diag_sum[i] = '0;
      end
   endfunction

   function automatic result_type predict_checksum(input checksum_req_type t);
      result_type  r;
      int unsigned l;
      int unsigned p;
      int unsigned n;
      int unsigned m;
      r = '0;
      l = saturated_length(line_length_q);
      if (t.opcode == OP_READ) begin
         if (t.read_index < l)
            r.check_byte = (t.read_line == LINE_DIAG) ? diag_sum[t.read_index]
                                                      : vert_sum[t.read_index];
         return r;
      end
      p = byte_pos;
      n = line_no;
      if (clear_due) begin
         clear_sums();
         clear_due = 1'b0;
      end
      if (p >= 1 && p <= MAX_BYTES) vert_sum[p] = vert_sum[p] - t.data_byte;
      take_off_diag(diag_entry(n, p, l), t.data_byte);
      if (p >= l - 1) begin
         byte_pos = 0;
         if (t.final_line || n >= l - 1) begin
            vert_sum[0] = l[7:0];
            take_off_diag(2, l);
            // missing lines carry only their number
            for (m = n + 1; m < l; m++) take_off_diag(diag_entry(m, 0, l), m);
            diag_sum[0] = l[7:0] + 8'd2;
            line_no = 1;
            clear_due = 1'b1;
            r.group_closed = 1'b1;
         end else begin
            line_no = n + 1;
         end
      end else begin
         byte_pos = p + 1;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 40) $display("%0t mismatch: %s", $time, msg);
   endtask

   task automatic push_byte(input logic [7:0] b, input logic fin);
      checksum_req_type t;
      t.opcode = OP_BYTE;
      t.data_byte = b;
      t.final_line = fin;
      t.read_line = 1'($urandom_range(0, 1));
      t.read_index = 6'($urandom_range(0, 63));
      pending_reqs.push_back(t);
      phase_count++;
      if (gen_pos >= gen_len - 1) begin
         gen_pos = 0;
         gen_line = (fin || gen_line >= gen_len - 1) ? 1 : gen_line + 1;
      end else begin
         gen_pos++;
      end
   endtask

   task automatic push_read(input logic rl, input logic [5:0] ri);
      checksum_req_type t;
      t.opcode = OP_READ;
      t.data_byte = 8'($urandom_range(0, 255));
      t.final_line = 1'($urandom_range(0, 1));
      t.read_line = rl;
      t.read_index = ri;
      pending_reqs.push_back(t);
      phase_count++;
   endtask

   function automatic logic [5:0] pick_index();
      if ($urandom_range(0, 3) == 0) return 6'($urandom_range(0, 63));
      return 6'($urandom_range(0, (gen_len > 63) ? 63 : gen_len));
   endfunction

   task automatic push_group();
      int unsigned lines;
      int unsigned k;
      int unsigned p;
      int unsigned n_reads;
      logic        fin;
      while (gen_pos != 0) push_byte(8'($urandom_range(0, 255)), 1'b0);
      lines = (gen_len <= 8) ? $urandom_range(1, gen_len - 1) : $urandom_range(1, 3);
      for (k = 0; k < lines; k++) begin
         for (p = 0; p < gen_len; p++) begin
            if ($urandom_range(0, 99) < 12) push_read(1'($urandom_range(0, 1)), pick_index());
            if (p == gen_len - 1)
               fin = (k == lines - 1) && (lines < gen_len - 1 || $urandom_range(0, 1) == 1);
            else
               fin = ($urandom_range(0, 9) == 0);
            push_byte((p == 0) ? gen_line[7:0] : 8'($urandom_range(0, 255)), fin);
         end
      end
      n_reads = $urandom_range(1, 4);
      repeat (n_reads) push_read(1'($urandom_range(0, 1)), pick_index());
   endtask

   task automatic push_noise();
      int unsigned n;
      n = $urandom_range(1, 8);
      repeat (n) begin
         if ($urandom_range(0, 1) == 1)
            push_read(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
         else
            push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic wait_until_idle();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_results.size() != 0);
   endtask

   task automatic write_line_length(input logic [6:0] v);
      wait_until_idle();
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_line_length <= v;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      line_length_q = v;
      gen_len = saturated_length(v);
      @(negedge clock);
   endtask

   task automatic run_random_phase(input logic [6:0] v);
      write_line_length(v);
      phase_count = 0;
      while (phase_count < PHASE_ITEMS) begin
         if ($urandom_range(0, 99) < 75) push_group();
         else push_noise();
      end
   endtask

   // driver: presents queued transfers and predicts each one as it is taken
   always @(posedge clock) begin : driver
      checksum_req_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_results.push_back(predict_checksum({req_opcode, req_data_byte,
               req_final_line, req_read_line, req_read_index}));
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_req = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_opcode <= next_req.opcode;
               req_data_byte <= next_req.data_byte;
               req_final_line <= next_req.final_line;
               req_read_line <= next_req.read_line;
               req_read_index <= next_req.read_index;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compares each result transfer with the oldest expectation
   always @(posedge clock) begin : monitor
      result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result transfer with nothing expected");
            end else begin
               want = expected_results.pop_front();
               if (rsp_check_byte !== want.check_byte)
                  report_mismatch($sformatf("check_byte got %h want %h",
                                            rsp_check_byte, want.check_byte));
               if (rsp_group_closed !== want.group_closed)
                  report_mismatch($sformatf("group_closed got %b want %b",
                                            rsp_group_closed, want.group_closed));
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb_block_two_dimensional_checksum_core NOT OK");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      int i;
      clear_sums();
      line_no = 1;
      byte_pos = 0;
      clear_due = 1'b1;
      line_length_q = LINE_LENGTH_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset length: reads before any data, out-of-range index, ignored fields
      push_read(LINE_VERT, 6'd0);
      push_read(LINE_DIAG, 6'd63);
      push_byte(8'hff, 1'b1);
      push_byte(8'h00, 1'b0);
      push_byte(8'h3c, 1'b0);
      // shrink mid-line: next byte is past the line end and closes on final_line
      write_line_length(7'd3);
      push_byte(8'h80, 1'b1);
      for (i = 0; i < 3; i++) push_read(LINE_VERT, 6'(i));
      for (i = 0; i < 4; i++) push_read(LINE_DIAG, 6'(i));
      // length below range saturates; group closes on line number
      write_line_length(7'd0);
      push_byte(8'd1, 1'b0);
      push_byte(8'haa, 1'b0);
      push_byte(8'h55, 1'b0);
      push_byte(8'd2, 1'b0);
      push_byte(8'hff, 1'b0);
      push_byte(8'h00, 1'b0);
      push_read(LINE_DIAG, 6'd2);
      push_read(LINE_VERT, 6'd63);

      for (i = 0; i < NUM_PHASES; i++) begin
         if (i == 4) begin
            send_idle_pct = 76;
            recv_idle_pct = 13;
         end else if (i == 8) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         run_random_phase(PHASE_LENGTHS[i]);
      end

      wait_until_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("tb_block_two_dimensional_checksum_core OK");
      else
         $display("tb_block_two_dimensional_checksum_core NOT OK");
      $finish;
   end

endmodule

>>> filelist.f
hdl/b2dc_pkg.sv
hdl/b2dc_sum_mem.sv
hdl/b2dc_ctrl.sv
hdl/block_two_dimensional_checksum_core.sv
verif/tb_block_two_dimensional_checksum_core.sv
